FILE: design/bld_pkg.sv
// Shared types and constants for the block liveness dataflow unit.
package bld_pkg;

  localparam int unsigned NumBlocks = 64;
  localparam int unsigned NumVregs  = 64;
  localparam int unsigned BlkW      = 6;
  localparam int unsigned RegW      = 6;
  localparam int unsigned CntW      = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;

  typedef logic [NumVregs-1:0] vmask_t;
  typedef logic [BlkW-1:0]     blk_t;

  typedef enum logic [1:0] {
    REQ_INSTR = 2'd0,
    REQ_EDGE  = 2'd1,
    REQ_RET   = 2'd2,
    REQ_RUN   = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VREG_COUNT  = 2'd0,
    CFG_BLOCK_COUNT = 2'd1,
    CFG_ENTRY_BLOCK = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_RUN_INIT,
    ST_RC_RD,
    ST_RC_UPD,
    ST_LV_RD,
    ST_LV_SRC,
    ST_LV_UPD,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_e;

  // successor row: count and two targets
  typedef struct packed {
    logic [1:0] cnt;
    blk_t       s1;
    blk_t       s0;
  } succ_row_t;

  typedef struct packed {
    logic accept;
    logic ret;
    logic ld_wr;
    logic run_init;
    logic addr_run;
    logic li_a_self;
    logic reach_upd;
    logic lv_old;
    logic lv_upd;
    logic emit;
    logic cnt_clr;
    logic cnt_inc;
    logic chg_clr;
  } cmd_t;

  typedef struct packed {
    logic last_blk;
    logic changed;
    logic nb_zero;
  } sts_t;

endpackage

FILE: design/block_liveness_dataflow_unit.sv
// Top level of the block liveness dataflow unit: controller plus datapath.
// An instruction or edge word holds busy for its table read-modify-write (ST_LD_WR);
// a return word is taken in idle and does not raise busy. A run holds busy through
// an init step, reachability sweeps and liveness sweeps to the fixpoint, and the
// output walk; each result word is read and then emitted, never back to back.
// Reset clears config to defaults; use/def, successor and live-in tables read as zero; no clearing pass.
module block_liveness_dataflow_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   req_type_i,
  input  logic [bld_pkg::BlkW-1:0]     block_index_i,
  input  logic                         first_of_block_i,
  input  logic                         dest_valid_i,
  input  logic [bld_pkg::RegW-1:0]     dest_reg_i,
  input  logic [bld_pkg::NumVregs-1:0] src_mask_i,
  input  logic [bld_pkg::BlkW-1:0]     succ_index_i,
  input  logic [bld_pkg::RegW-1:0]     return_reg_i,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [bld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bld_pkg::CfgDataW-1:0] cfg_data_i,
  // result words, one cycle each, no backpressure
  output logic                         out_strobe_o,
  output logic [bld_pkg::BlkW-1:0]     out_block_o,
  output logic [bld_pkg::NumVregs-1:0] live_in_mask_o,
  output logic [bld_pkg::NumVregs-1:0] live_out_mask_o,
  output logic                         last_o
);
  import bld_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: load writes, reach sweeps, liveness sweeps, output walk
  bld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  // set tables live in the datapath; it also owns the config registers
  bld_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .block_index_i    (block_index_i),
    .req_type_i       (req_type_i),
    .first_of_block_i (first_of_block_i),
    .dest_valid_i     (dest_valid_i),
    .dest_reg_i       (dest_reg_i),
    .src_mask_i       (src_mask_i),
    .succ_index_i     (succ_index_i),
    .return_reg_i     (return_reg_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_block_o      (out_block_o),
    .live_in_mask_o   (live_in_mask_o),
    .live_out_mask_o  (live_out_mask_o),
    .last_o           (last_o)
  );

  assign out_strobe_o = cmd.emit;

endmodule

FILE: design/bld_ctrl.sv
// Sequencer for loading, reachability, liveness sweeps and result output.
module bld_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    req_type_i,
  input  bld_pkg::sts_t sts_i,
  output bld_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import bld_pkg::*;

  state_e state_q, state_d;
  req_e   req;

  assign req    = req_e'(req_type_i);
  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req)
            REQ_INSTR, REQ_EDGE: state_d = ST_LD_WR;
            REQ_RUN:             state_d = ST_RUN_INIT;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_LD_WR:    state_d = ST_IDLE;
      ST_RUN_INIT: state_d = sts_i.nb_zero ? ST_IDLE : ST_RC_RD;
      ST_RC_RD:    state_d = ST_RC_UPD;
      ST_RC_UPD: begin
        if (!sts_i.last_blk)     state_d = ST_RC_RD;
        else if (sts_i.changed)  state_d = ST_RC_RD;
        else                     state_d = ST_LV_RD;
      end
      ST_LV_RD:  state_d = ST_LV_SRC;
      ST_LV_SRC: state_d = ST_LV_UPD;
      ST_LV_UPD: begin
        if (!sts_i.last_blk)     state_d = ST_LV_RD;
        else if (sts_i.changed)  state_d = ST_LV_RD;
        else                     state_d = ST_OUT_RD;
      end
      ST_OUT_RD:   state_d = ST_OUT_EMIT;
      ST_OUT_EMIT: state_d = sts_i.last_blk ? ST_IDLE : ST_OUT_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = start_i;
        cmd_o.ret    = start_i && (req == REQ_RET);
      end
      ST_LD_WR: cmd_o.ld_wr = 1'b1;
      ST_RUN_INIT: begin
        cmd_o.run_init = 1'b1;
        cmd_o.cnt_clr  = 1'b1;
        cmd_o.chg_clr  = 1'b1;
      end
      ST_RC_RD: cmd_o.addr_run = 1'b1;
      ST_RC_UPD: begin
        cmd_o.addr_run  = 1'b1;
        cmd_o.reach_upd = 1'b1;
        cmd_o.cnt_clr   = sts_i.last_blk;
        cmd_o.chg_clr   = sts_i.last_blk;
        cmd_o.cnt_inc   = !sts_i.last_blk;
      end
      ST_LV_RD: begin
        cmd_o.addr_run  = 1'b1;
        cmd_o.li_a_self = 1'b1;
      end
      ST_LV_SRC: begin
        cmd_o.addr_run = 1'b1;
        cmd_o.lv_old   = 1'b1;
      end
      ST_LV_UPD: begin
        cmd_o.addr_run = 1'b1;
        cmd_o.lv_upd   = 1'b1;
        cmd_o.cnt_clr  = sts_i.last_blk;
        cmd_o.chg_clr  = sts_i.last_blk;
        cmd_o.cnt_inc  = !sts_i.last_blk;
      end
      ST_OUT_RD: begin
        cmd_o.addr_run  = 1'b1;
        cmd_o.li_a_self = 1'b1;
      end
      ST_OUT_EMIT: begin
        cmd_o.addr_run = 1'b1;
        cmd_o.emit     = 1'b1;
        cmd_o.cnt_inc  = !sts_i.last_blk;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: design/bld_dp.sv
// Set tables, successor table, reachability vector and liveness update datapath.
module bld_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bld_pkg::cmd_t                cmd_i,
  output bld_pkg::sts_t                sts_o,
  input  logic [bld_pkg::BlkW-1:0]     block_index_i,
  input  logic [1:0]                   req_type_i,
  input  logic                         first_of_block_i,
  input  logic                         dest_valid_i,
  input  logic [bld_pkg::RegW-1:0]     dest_reg_i,
  input  logic [bld_pkg::NumVregs-1:0] src_mask_i,
  input  logic [bld_pkg::BlkW-1:0]     succ_index_i,
  input  logic [bld_pkg::RegW-1:0]     return_reg_i,
  input  logic                         cfg_we_i,
  input  logic [bld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bld_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [bld_pkg::BlkW-1:0]     out_block_o,
  output logic [bld_pkg::NumVregs-1:0] live_in_mask_o,
  output logic [bld_pkg::NumVregs-1:0] live_out_mask_o,
  output logic                         last_o
);
  import bld_pkg::*;

  // config
  logic [CntW-1:0] vreg_count_q, block_count_q;
  blk_t            entry_q;

  // latched load word
  req_e            req_q;
  blk_t            blk_q;
  logic            first_q, dv_q;
  logic [RegW-1:0] dest_q;
  vmask_t          src_q;
  blk_t            succ_q;

  vmask_t          ret_q, dsf_q;
  logic [NumBlocks-1:0] reach_q, ud_vld_q, sv_vld_q, li_vld_q;
  blk_t            cnt_q;
  logic            changed_q;

  // memories
  vmask_t    use_mem [NumBlocks];
  vmask_t    def_mem [NumBlocks];
  vmask_t    li_mem  [NumBlocks];
  vmask_t    lo_mem  [NumBlocks];
  succ_row_t succ_mem [NumBlocks];

  vmask_t    use_rd_q, def_rd_q, lia_rd_q, lib_rd_q, lo_rd_q, old_li_q;
  succ_row_t succ_rd_q;
  logic      ud_v_q, sv_v_q, lia_v_q, lib_v_q;

  blk_t      addr, li_addr_a;
  vmask_t    use_rd, def_rd, lia, lib, vm;
  succ_row_t srow, srow_new;
  logic [CntW-1:0] nb;
  logic      t0_ok, t1_ok, new0, new1, chg_now;
  vmask_t    use_new, def_new, dsf_base, dmask, lo_new, li_new;

  // effective block count and register mask
  assign nb = (block_count_q > CntW'(NumBlocks)) ? CntW'(NumBlocks) : block_count_q;
  assign vm = (vreg_count_q >= CntW'(NumVregs)) ? '1
            : ((vmask_t'(1) << vreg_count_q[RegW-1:0]) - vmask_t'(1));

  assign addr      = cmd_i.addr_run ? cnt_q : block_index_i;
  assign srow      = sv_v_q ? succ_rd_q : '0;
  assign li_addr_a = cmd_i.li_a_self ? cnt_q : srow.s0;
  assign use_rd    = ud_v_q ? use_rd_q : '0;
  assign def_rd    = ud_v_q ? def_rd_q : '0;
  assign lia       = lia_v_q ? lia_rd_q : '0;
  assign lib       = lib_v_q ? lib_rd_q : '0;

  assign t0_ok = (srow.cnt >= 2'd1) && ({1'b0, srow.s0} < nb);
  assign t1_ok = (srow.cnt >= 2'd2) && ({1'b0, srow.s1} < nb);

  // load updates
  assign dsf_base = first_q ? '0 : dsf_q;
  assign dmask    = dv_q ? (vmask_t'(1) << dest_q) : '0;
  assign use_new  = (first_q ? '0 : use_rd) | (src_q & ~dsf_base);
  assign def_new  = (first_q ? '0 : def_rd) | dmask;

  always_comb begin
    srow_new = srow;
    if (srow.cnt == 2'd0) begin
      srow_new.s0  = succ_q;
      srow_new.cnt = 2'd1;
    end else if (srow.cnt == 2'd1) begin
      srow_new.s1  = succ_q;
      srow_new.cnt = 2'd2;
    end
  end

  // liveness equations for block cnt_q
  assign lo_new = ((srow.cnt == 2'd0) ? ret_q
                   : ((t0_ok ? lia : '0) | (t1_ok ? lib : '0))) & vm;
  assign li_new = (use_rd | (lo_new & ~def_rd)) & vm;

  assign new0 = reach_q[cnt_q] && t0_ok && !reach_q[srow.s0];
  assign new1 = reach_q[cnt_q] && t1_ok && !reach_q[srow.s1];

  always_comb begin
    chg_now = 1'b0;
    if (cmd_i.reach_upd) chg_now = new0 || new1;
    if (cmd_i.lv_upd)    chg_now = reach_q[cnt_q] && (li_new != old_li_q);
  end

  assign sts_o.changed  = changed_q || chg_now;
  assign sts_o.last_blk = ({1'b0, cnt_q} == (nb - CntW'(1)));
  assign sts_o.nb_zero  = (nb == '0);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vreg_count_q  <= CntW'(NumVregs);
      block_count_q <= CntW'(NumBlocks);
      entry_q       <= '0;
      ret_q         <= '0;
      dsf_q         <= '0;
      reach_q       <= '0;
      ud_vld_q      <= '0;
      sv_vld_q      <= '0;
      li_vld_q      <= '0;
      cnt_q         <= '0;
      changed_q     <= 1'b0;
      ud_v_q        <= 1'b0;
      sv_v_q        <= 1'b0;
      lia_v_q       <= 1'b0;
      lib_v_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_VREG_COUNT:  vreg_count_q  <= cfg_data_i;
          CFG_BLOCK_COUNT: block_count_q <= cfg_data_i;
          CFG_ENTRY_BLOCK: entry_q       <= cfg_data_i[BlkW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.ret) ret_q <= ret_q | (vmask_t'(1) << return_reg_i);
      if (cmd_i.ld_wr) begin
        if (req_q == REQ_INSTR) begin
          dsf_q           <= dsf_base | dmask;
          ud_vld_q[blk_q] <= 1'b1;
        end else begin
          sv_vld_q[blk_q] <= 1'b1;
        end
      end
      if (cmd_i.run_init) begin
        reach_q  <= ({1'b0, entry_q} < nb) ? (NumBlocks'(1) << entry_q) : '0;
        li_vld_q <= '0;
      end
      if (cmd_i.reach_upd) begin
        reach_q <= reach_q | (new0 ? (NumBlocks'(1) << srow.s0) : '0)
                           | (new1 ? (NumBlocks'(1) << srow.s1) : '0);
      end
      if (cmd_i.lv_upd && reach_q[cnt_q]) li_vld_q[cnt_q] <= 1'b1;
      if (cmd_i.cnt_clr)      cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + BlkW'(1);
      changed_q <= cmd_i.chg_clr ? 1'b0 : (changed_q || chg_now);
      ud_v_q  <= ud_vld_q[addr];
      sv_v_q  <= sv_vld_q[addr];
      lia_v_q <= li_vld_q[li_addr_a];
      lib_v_q <= li_vld_q[srow.s1];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= req_e'(req_type_i);
      blk_q   <= block_index_i;
      first_q <= first_of_block_i;
      dv_q    <= dest_valid_i;
      dest_q  <= dest_reg_i;
      src_q   <= src_mask_i;
      succ_q  <= succ_index_i;
    end
    if (cmd_i.lv_old) old_li_q <= lia;
  end

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_wr) begin
      if (req_q == REQ_INSTR) begin
        use_mem[blk_q] <= use_new;
        def_mem[blk_q] <= def_new;
      end else begin
        succ_mem[blk_q] <= srow_new;
      end
    end
    if (cmd_i.lv_upd && reach_q[cnt_q]) begin
      li_mem[cnt_q] <= li_new;
      lo_mem[cnt_q] <= lo_new;
    end
    use_rd_q  <= use_mem[addr];
    def_rd_q  <= def_mem[addr];
    succ_rd_q <= succ_mem[addr];
    lo_rd_q   <= lo_mem[addr];
    lia_rd_q  <= li_mem[li_addr_a];
    lib_rd_q  <= li_mem[srow.s1];
  end

  // result word
  assign out_block_o     = cnt_q;
  assign live_in_mask_o  = reach_q[cnt_q] ? lia : '0;
  assign live_out_mask_o = reach_q[cnt_q] ? lo_rd_q : '0;
  assign last_o          = sts_o.last_blk;

endmodule

FILE: design/bld_checker.sv
// Port-level checks for the block liveness dataflow unit, bound to the top level.
module bld_port_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy_o,
  input logic       out_strobe_o,
  input logic [5:0] out_block_o,
  input logic       last_o
);

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> busy_o)
    else $error("result word outside a run");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && last_o |=> !out_strobe_o && !busy_o)
    else $error("run did not end after last word");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_o |=> !out_strobe_o && busy_o)
    else $error("result words not spaced");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_o |-> ##2 (out_strobe_o &&
      out_block_o == 6'($past(out_block_o, 2) + 6'd1)))
    else $error("blocks not in order");

endmodule

bind block_liveness_dataflow_unit bld_port_props u_bld_port_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy_o       (busy_o),
  .out_strobe_o (out_strobe_o),
  .out_block_o  (out_block_o),
  .last_o       (last_o)
);
